// ===== rtl/fps_pkg.sv =====
// ----------------------------------------------------------------------------
// fps_pkg
// shared widths, the limit reset value and the per-channel state entry type
// ----------------------------------------------------------------------------
package fps_pkg;

  localparam int ChannelW       = 6;
  localparam int SampleW        = 16;
  localparam int LimitW         = 15;
  localparam int NumChannelsDef = 64;

  localparam logic [LimitW-1:0] LimitReset = LimitW'(10);

  // pedestal and accumulator of one channel, held together in one word
  typedef struct packed {
    logic signed [SampleW-1:0] ped;
    logic signed [SampleW-1:0] acc;
  } fps_entry_t;

endpackage

// ===== rtl/fps_in_if.sv =====
// ----------------------------------------------------------------------------
// fps_in_if
// sample request channel: channel number and raw sample
// ----------------------------------------------------------------------------
interface fps_in_if;
  logic                                    valid;
  logic                                    ready;
  logic        [fps_pkg::ChannelW-1:0]     channel;
  logic signed [fps_pkg::SampleW-1:0]      sample;

  modport source (output valid, channel, sample, input ready);
  modport sink   (input valid, channel, sample, output ready);
endinterface

// ===== rtl/fps_out_if.sv =====
// ----------------------------------------------------------------------------
// fps_out_if
// result request channel: channel, corrected sample and pedestal
// ----------------------------------------------------------------------------
interface fps_out_if;
  logic                                    valid;
  logic                                    ready;
  logic        [fps_pkg::ChannelW-1:0]     channel_out;
  logic signed [fps_pkg::SampleW-1:0]      corrected;
  logic signed [fps_pkg::SampleW-1:0]      pedestal_out;

  modport source (output valid, channel_out, corrected, pedestal_out, input ready);
  modport sink   (input valid, channel_out, corrected, pedestal_out, output ready);
endinterface

// ===== rtl/fps_state_mem.sv =====
// ----------------------------------------------------------------------------
// fps_state_mem
// per-channel state memory, registered read, with a clearing sweep after reset
// ----------------------------------------------------------------------------
module fps_state_mem #(
  parameter int NumChannels = fps_pkg::NumChannelsDef,
  parameter int IdxW        = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [IdxW-1:0]     raddr_i,
  output fps_pkg::fps_entry_t rdata_o,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  fps_pkg::fps_entry_t wdata_i,
  output logic                busy_o
);
  import fps_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumChannels - 1);

  fps_entry_t mem [NumChannels];
  fps_entry_t rdata_q;

  logic            clr_q, clr_d;
  logic [IdxW-1:0] clr_idx_q, clr_idx_d;

  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  fps_entry_t      mem_wdata;

  always_comb begin
    clr_d     = clr_q;
    clr_idx_d = clr_idx_q;
    if (clr_q) begin
      clr_idx_d = clr_idx_q + IdxW'(1);
      if (clr_idx_q == LastIdx) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  assign mem_we    = clr_q | we_i;
  assign mem_waddr = clr_q ? clr_idx_q : waddr_i;
  assign mem_wdata = clr_q ? '0 : wdata_i;

  // read-before-write: a read of the entry being written returns the old word
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_q;

`ifndef SYNTH
  a_no_write_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !we_i)
    else $error("state write during clearing sweep");

  a_sweep_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clr_q && clr_idx_q != LastIdx) |=> (clr_q && clr_idx_q == $past(clr_idx_q) + IdxW'(1)))
    else $error("clearing sweep skipped an entry");

  a_sweep_ends_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_q |=> !clr_q)
    else $error("clearing sweep restarted");
`endif

endmodule

// ===== rtl/fps_update.sv =====
// ----------------------------------------------------------------------------
// fps_update
// one frugal median step on a channel entry, and the corrected sample
// ----------------------------------------------------------------------------
module fps_update (
  input  fps_pkg::fps_entry_t                  entry_i,
  input  logic signed [fps_pkg::SampleW-1:0]   sample_i,
  input  logic        [fps_pkg::LimitW-1:0]    limit_i,
  input  logic                                 in_range_i,
  output fps_pkg::fps_entry_t                  entry_o,
  output logic signed [fps_pkg::SampleW-1:0]   corrected_o,
  output logic signed [fps_pkg::SampleW-1:0]   pedestal_o
);
  import fps_pkg::*;

  localparam logic signed [SampleW-1:0] PedMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] PedMin = {1'b1, {(SampleW-1){1'b0}}};

  logic signed [SampleW-1:0] acc_step;
  logic signed [SampleW:0]   acc_wide;
  logic signed [SampleW:0]   lim_pos;
  logic signed [SampleW:0]   lim_neg;
  logic signed [SampleW-1:0] ped_new;

  always_comb begin
    if (sample_i > entry_i.ped) begin
      acc_step = entry_i.acc + SampleW'(1);
    end else if (sample_i < entry_i.ped) begin
      acc_step = entry_i.acc - SampleW'(1);
    end else begin
      acc_step = entry_i.acc;
    end

    acc_wide = {acc_step[SampleW-1], acc_step};
    lim_pos  = $signed({2'b00, limit_i});
    lim_neg  = -lim_pos;

    entry_o.ped = entry_i.ped;
    entry_o.acc = acc_step;
    if (acc_wide > lim_pos) begin
      if (entry_i.ped != PedMax) begin
        entry_o.ped = entry_i.ped + SampleW'(1);
      end
      entry_o.acc = '0;
    end else if (acc_wide < lim_neg) begin
      if (entry_i.ped != PedMin) begin
        entry_o.ped = entry_i.ped - SampleW'(1);
      end
      entry_o.acc = '0;
    end

    // channels beyond the store see a zero pedestal
    ped_new     = in_range_i ? entry_o.ped : '0;
    corrected_o = sample_i - ped_new;
    pedestal_o  = ped_new;
  end

endmodule

// ===== rtl/frugal_pedestal_subtract.sv =====
// ----------------------------------------------------------------------------
// frugal_pedestal_subtract
// per-channel frugal streaming median pedestal tracking and subtraction
// ----------------------------------------------------------------------------
//
//  port     dir  handshake     payload
//  -------  ---  ------------  ---------------------------------------------
//  in_i     in   valid/ready   channel (6b), sample (s16)
//  out_o    out  valid/ready   channel_out (6b), corrected (s16), pedestal_out (s16)
//  cfg      in   cfg_we_i      cfg_wdata_i: accumulator limit (15b)
//
//  one request per cycle sustained while out_o is ready; a request passes the
//  state memory read, then the update and result register, before its result is valid
//  after reset the state memory is swept to zero, one entry a cycle, and
//  in_i.ready stays low until the sweep ends; configuration is taken anyway
//  a stall on out_o holds the update stage and then the input; the memory is
//  re-read for the held request so its state stays current
//
module frugal_pedestal_subtract #(
  parameter int NumChannels = fps_pkg::NumChannelsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fps_pkg::LimitW-1:0]    cfg_wdata_i,
  fps_in_if.sink                        in_i,
  fps_out_if.source                     out_o
);
  import fps_pkg::*;

  localparam int IdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  // configuration register
  logic [LimitW-1:0] limit_q;

  // update stage: request whose state word is being read
  logic                      s1_valid_q, s1_valid_d;
  logic [ChannelW-1:0]       s1_ch_q;
  logic signed [SampleW-1:0] s1_smp_q;
  logic                      s1_inr_q;
  logic [IdxW-1:0]           s1_idx_q;

  // last write, forwarded to a back-to-back request on the same channel
  logic                      fwd_valid_q;
  logic [IdxW-1:0]           fwd_idx_q;
  fps_entry_t                fwd_entry_q;

  // result register
  logic                      out_valid_q, out_valid_d;
  logic [ChannelW-1:0]       out_ch_q;
  logic signed [SampleW-1:0] out_corr_q;
  logic signed [SampleW-1:0] out_ped_q;

  logic                      in_fire;
  logic                      s1_fire;
  logic                      mem_busy;
  logic [IdxW-1:0]           in_idx;
  logic                      in_inr;
  logic [IdxW-1:0]           raddr;
  fps_entry_t                rdata;
  fps_entry_t                cur_entry;
  fps_entry_t                new_entry;
  logic signed [SampleW-1:0] corr;
  logic signed [SampleW-1:0] ped_out;
  logic                      mem_we;

  // handshake and stage advance
  assign s1_fire     = s1_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready  = ~mem_busy & (~s1_valid_q | s1_fire);
  assign in_fire     = in_i.valid & in_i.ready;
  assign s1_valid_d  = in_fire | (s1_valid_q & ~s1_fire);
  assign out_valid_d = s1_fire | (out_valid_q & ~out_o.ready);

  assign in_idx = IdxW'(in_i.channel);
  assign in_inr = 32'(in_i.channel) < NumChannels;

  // re-read the held request while stalled so a late write is seen
  assign raddr = in_fire ? in_idx : s1_idx_q;

  // write of the previous cycle is not yet in the registered read data
  assign cur_entry = (fwd_valid_q && fwd_idx_q == s1_idx_q) ? fwd_entry_q : rdata;

  assign mem_we = s1_fire & s1_inr_q;

  fps_state_mem #(
    .NumChannels (NumChannels),
    .IdxW        (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .we_i    (mem_we),
    .waddr_i (s1_idx_q),
    .wdata_i (new_entry),
    .busy_o  (mem_busy)
  );

  fps_update u_update (
    .entry_i     (cur_entry),
    .sample_i    (s1_smp_q),
    .limit_i     (limit_q),
    .in_range_i  (s1_inr_q),
    .entry_o     (new_entry),
    .corrected_o (corr),
    .pedestal_o  (ped_out)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LimitReset;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      fwd_valid_q <= mem_we;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ch_q  <= in_i.channel;
      s1_smp_q <= in_i.sample;
      s1_inr_q <= in_inr;
      s1_idx_q <= in_idx;
    end
    if (mem_we) begin
      fwd_idx_q   <= s1_idx_q;
      fwd_entry_q <= new_entry;
    end
    if (s1_fire) begin
      out_ch_q   <= s1_ch_q;
      out_corr_q <= corr;
      out_ped_q  <= ped_out;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.channel_out  = out_ch_q;
  assign out_o.corrected    = out_corr_q;
  assign out_o.pedestal_out = out_ped_q;

`ifndef SYNTH
  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_busy |-> !in_fire)
    else $error("request accepted during clearing sweep");

  a_update_lands_in_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("update stage fired without a result");

  a_fwd_follows_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_valid_q |-> ($past(s1_fire) && $past(s1_inr_q)))
    else $error("forward entry without a preceding write");

  a_stage_not_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_fire) |=> (s1_valid_q && $stable(s1_smp_q)))
    else $error("held request lost in update stage");
`endif

endmodule

// ===== sim/fps_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_tb_pkg
// per-channel pedestal tracker for the testbench: predicts each result from
// the accepted requests and checks the results the block returns, in order
// ----------------------------------------------------------------------------
package fps_tb_pkg;

  import fps_pkg::*;

  typedef struct packed {
    logic        [ChannelW-1:0] channel;
    logic signed [SampleW-1:0]  corrected;
    logic signed [SampleW-1:0]  pedestal;
  } fps_result_t;

  class pedestal_tracker;
    logic signed [SampleW-1:0] ped_mem [NumChannelsDef];
    logic signed [SampleW-1:0] acc_mem [NumChannelsDef];
    logic        [LimitW-1:0]  limit;
    fps_result_t               expected_results [$];
    int                        failures;

    function new();
      foreach (ped_mem[i]) begin
        ped_mem[i] = '0;
        acc_mem[i] = '0;
      end
      limit    = LimitReset;
      failures = 0;
    endfunction

    function void set_limit(logic [LimitW-1:0] value);
      limit = value;
    endfunction

    function logic signed [SampleW-1:0] pedestal_of(logic [ChannelW-1:0] channel);
      if (int'(channel) < NumChannelsDef) begin
        return ped_mem[channel];
      end
      return '0;
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction

    function void complain(string msg);
      failures++;
      if (failures <= 10) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endfunction

    // one accepted request: update the channel state, queue its result
    function void note_sample(logic [ChannelW-1:0] channel, logic signed [SampleW-1:0] sample);
      logic signed [SampleW-1:0] ped;
      logic signed [SampleW-1:0] acc;
      int                        lim;
      fps_result_t               res;
      ped = '0;
      if (int'(channel) < NumChannelsDef) begin
        ped = ped_mem[channel];
        acc = acc_mem[channel];
        lim = int'(limit);
        // accumulator wraps at 16 bits
        if (sample > ped) begin
          acc = acc + 16'sd1;
        end else if (sample < ped) begin
          acc = acc - 16'sd1;
        end
        if (int'(acc) > lim) begin
          if (ped != 16'sh7fff) begin
            ped = ped + 16'sd1;
          end
          acc = '0;
        end else if (int'(acc) < -lim) begin
          if (ped != 16'sh8000) begin
            ped = ped - 16'sd1;
          end
          acc = '0;
        end
        ped_mem[channel] = ped;
        acc_mem[channel] = acc;
      end
      res.channel   = channel;
      res.corrected = sample - ped;
      res.pedestal  = ped;
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [ChannelW-1:0] channel, logic signed [SampleW-1:0] corrected,
                               logic signed [SampleW-1:0] pedestal);
      fps_result_t want;
      if (expected_results.size() == 0) begin
        complain($sformatf("result ch %0d corr %0d ped %0d with no request outstanding",
                           channel, corrected, pedestal));
        return;
      end
      want = expected_results.pop_front();
      if (want.channel !== channel || want.corrected !== corrected ||
          want.pedestal !== pedestal) begin
        complain($sformatf("expected ch %0d corr %0d ped %0d, got ch %0d corr %0d ped %0d",
                           want.channel, want.corrected, want.pedestal,
                           channel, corrected, pedestal));
      end
    endfunction
  endclass

endpackage

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives sample requests into the pedestal subtractor, with random gaps on
// both sides, and checks each result against the pedestal tracker
// ----------------------------------------------------------------------------
module tb;

  import fps_pkg::*;
  import fps_tb_pkg::*;

  // cycles with no request moving on either side before the run is given up
  localparam int WatchdogLimit = 2000;
  // pipeline settling after the last result
  localparam int SettleCycles  = 4;
  localparam int RandomPerPhase = 60;
  localparam int NumPhases      = 8;
  // limits for the random phases, both ends of the range among them
  localparam logic [LimitW-1:0] PhaseLimits [NumPhases] =
    '{15'd2, 15'd32766, 15'd0, 15'd5, 15'd1, 15'd10, 15'd3, 15'd32767};

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [LimitW-1:0] cfg_wdata_i = '0;
  logic              rx_ready    = 1'b0;
  // when set, neither side idles
  bit                no_idle     = 1'b0;
  int                quiet_cycles = 0;

  pedestal_tracker           tracker;
  // per-channel level the random samples cluster around
  logic signed [SampleW-1:0] baseline [NumChannelsDef];

  fps_in_if  in_if ();
  fps_out_if out_if ();

  assign out_if.ready = rx_ready;

  always #5 clk_i = ~clk_i;

  frugal_pedestal_subtract i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // receiver: stalls about a quarter of the time unless told not to
  always @(negedge clk_i) begin
    rx_ready <= no_idle || ($urandom_range(99) >= 24);
  end

  // monitor: results are checked before the request of the same edge is noted,
  // limit writes only land while nothing is in flight
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        tracker.check_result(out_if.channel_out, out_if.corrected, out_if.pedestal_out);
      end
      if (in_if.valid && in_if.ready) begin
        tracker.note_sample(in_if.channel, in_if.sample);
      end
      if (cfg_we_i) begin
        tracker.set_limit(cfg_wdata_i);
      end
    end
  end

  // watchdog: counts cycles in which no request moves on either side
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // one request; entered and left at a falling edge
  task automatic send_sample(input logic [ChannelW-1:0] ch, input logic signed [SampleW-1:0] smp);
    while (!no_idle && $urandom_range(99) < 24) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.channel <= ch;
    in_if.sample  <= smp;
    forever begin
      @(posedge clk_i);
      if (in_if.ready) break;
    end
    @(negedge clk_i);
  endtask

  task automatic send_run(input logic [ChannelW-1:0] ch, input logic signed [SampleW-1:0] smp,
                          input int count);
    repeat (count) send_sample(ch, smp);
  endtask

  // hold the sender until every outstanding result has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // limit write, only with the pipeline empty
  task automatic write_limit(input logic [LimitW-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly small channel numbers so accumulators actually reach the limit;
  // samples hug the tracked pedestal, the channel baseline, or anything at all
  task automatic send_random();
    logic        [ChannelW-1:0] ch;
    logic signed [SampleW-1:0]  smp;
    int                         pick;
    if ($urandom_range(99) < 75) begin
      ch = ChannelW'($urandom_range(7));
    end else begin
      ch = ChannelW'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 45) begin
      smp = tracker.pedestal_of(ch) + SampleW'($urandom_range(6)) - SampleW'(3);
    end else if (pick < 75) begin
      smp = baseline[ch] + SampleW'($urandom_range(31)) - SampleW'(16);
    end else begin
      smp = SampleW'($urandom);
    end
    send_sample(ch, smp);
  endtask

  initial begin
    tracker = new();
    in_if.valid   <= 1'b0;
    in_if.channel <= '0;
    in_if.sample  <= '0;
    foreach (baseline[i]) begin
      baseline[i] = SampleW'($urandom);
    end

    // reset held, then released; the block then sweeps its state memory
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset limit: sample extremes, channel extremes, sample equal to pedestal
    send_sample(6'd0, 16'sh7fff);
    send_sample(6'd63, 16'sh8000);
    send_sample(6'd0, 16'sh0000);
    send_sample(6'd1, 16'sh5555);
    send_sample(6'd1, 16'shaaaa);
    send_sample(6'd63, 16'sh0000);

    // zero limit: every step above or below moves the pedestal
    write_limit(15'd0);
    send_run(6'd2, 16'sd100, 3);
    send_sample(6'd2, -16'sd100);
    send_sample(6'd2, 16'sd2);
    send_run(6'd62, 16'sh8000, 2);

    // limit of one: pedestal moves on the second step either way
    write_limit(15'd1);
    send_run(6'd3, 16'sd5, 2);
    send_run(6'd3, -16'sd5, 2);
    send_sample(6'd3, 16'sd0);

    // stretch with no idling on either side: back-to-back requests on one
    // channel pull its pedestal down every cycle, then push it back up
    no_idle = 1'b1;
    write_limit(15'd0);
    send_run(6'd7, 16'sh8000, 24);
    write_limit(15'd3);
    send_run(6'd7, 16'sh7fff, 24);
    no_idle = 1'b0;

    // random phases over a spread of limits
    for (int phase = 0; phase < NumPhases; phase++) begin
      write_limit(PhaseLimits[phase]);
      no_idle = (phase == 3);
      for (int n = 0; n < RandomPerPhase; n++) begin
        // sender holds off mid-phase until the pipeline has emptied
        if (phase == 1 && n == RandomPerPhase / 2) begin
          drain_results();
        end
        send_random();
      end
    end
    no_idle = 1'b0;

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fps_pkg.sv
rtl/fps_in_if.sv
rtl/fps_out_if.sv
rtl/fps_state_mem.sv
rtl/fps_update.sv
rtl/frugal_pedestal_subtract.sv
sim/fps_tb_pkg.sv
sim/tb.sv
